FILE: hw/rtl/mvtp_pkg.sv
// Shared types, constants and a helper function for the vertex transform block.
package mvtp_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int ACC_WIDTH  = 2 * WORD_WIDTH + 2;
    localparam int RND_WIDTH  = ACC_WIDTH - FRAC_BITS;
    localparam int DIV_WIDTH  = WORD_WIDTH + FRAC_BITS;
    localparam int DCNT_WIDTH = $clog2(DIV_WIDTH);

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_XFORM   = 2'd1;
    localparam logic [1:0] OP_PROJECT = 2'd2;
    localparam logic [1:0] OP_NOP     = 2'd3;

    localparam logic signed [WORD_WIDTH-1:0] FX_ONE  =
        WORD_WIDTH'(longint'(1) << FRAC_BITS);
    localparam logic signed [WORD_WIDTH-1:0] W_MAX   = {1'b0, {(WORD_WIDTH-1){1'b1}}};
    localparam logic signed [WORD_WIDTH-1:0] W_MIN   = {1'b1, {(WORD_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  elem_index;
        logic signed [31:0] elem_value;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] w;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
        logic signed [31:0] rw;
        logic        div_zero;
        logic        saturated;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_FLUSH,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic       load;
        logic       start;
        logic       mac_go;
        logic [3:0] mac_idx;
        logic       zero_fill;
        logic       div_start;
        logic [1:0] div_k;
        logic       push;
    } cmd_t;

    typedef struct packed {
        logic mac_busy;
        logic w_zero;
        logic div_done;
    } status_t;

    function automatic logic signed [WORD_WIDTH-1:0] round_clamp(
        input logic signed [ACC_WIDTH-1:0] acc,
        output logic sat);
        logic signed [ACC_WIDTH-1:0] rnd;
        logic signed [RND_WIDTH-1:0] sh;
        logic signed [WORD_WIDTH-1:0] res;
        rnd = acc + ACC_WIDTH'(longint'(1) << (FRAC_BITS - 1));
        sh  = RND_WIDTH'(rnd >>> FRAC_BITS);
        sat = 1'b0;
        res = WORD_WIDTH'(sh);
        if (sh > RND_WIDTH'(W_MAX)) begin
            sat = 1'b1;
            res = W_MAX;
        end else if (sh < RND_WIDTH'(W_MIN)) begin
            sat = 1'b1;
            res = W_MIN;
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/mvtp_div.sv
// Bit-serial restoring divider giving a saturated fixed-point quotient.
module mvtp_div (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [mvtp_pkg::WORD_WIDTH-1:0] n,
    input  logic signed [mvtp_pkg::WORD_WIDTH-1:0] d,
    output logic                                  done,
    output logic signed [mvtp_pkg::WORD_WIDTH-1:0] q,
    output logic                                  sat
);

    localparam int WW = mvtp_pkg::WORD_WIDTH;
    localparam int DW = mvtp_pkg::DIV_WIDTH;
    localparam int CW = mvtp_pkg::DCNT_WIDTH;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [DW-1:0]       dvd_reg, dvd_next;
    logic [DW-1:0]       quo_reg, quo_next;
    logic [WW-1:0]       rem_reg, rem_next;
    logic [WW-1:0]       dsr_reg, dsr_next;
    logic                neg_reg, neg_next;
    logic [WW:0]         rem_sh;
    logic                take;
    logic [DW-1:0]       lim;
    logic [WW-1:0]       a_abs, b_abs;

    always_comb
    begin
        a_abs     = n[WW-1] ? WW'(-n) : WW'(n);
        b_abs     = d[WW-1] ? WW'(-d) : WW'(d);
        rem_sh    = {rem_reg, dvd_reg[DW-1]};
        take      = rem_sh >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = {a_abs, {mvtp_pkg::FRAC_BITS{1'b0}}};
            quo_next  = '0;
            rem_next  = '0;
            dsr_next  = b_abs;
            neg_next  = n[WW-1] ^ d[WW-1];
        end else if (busy_reg) begin
            rem_next = take ? WW'(rem_sh - {1'b0, dsr_reg}) : WW'(rem_sh);
            quo_next = {quo_reg[DW-2:0], take};
            dvd_next = {dvd_reg[DW-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        lim  = neg_reg ? DW'({1'b1, {(WW-1){1'b0}}}) : DW'({1'b0, {(WW-1){1'b1}}});
        done = done_reg;
        sat  = quo_reg > lim;
        if (sat)
            q = neg_reg ? mvtp_pkg::W_MIN : mvtp_pkg::W_MAX;
        else
            q = neg_reg ? WW'(-quo_reg[WW-1:0]) : quo_reg[WW-1:0];
    end

endmodule

FILE: hw/rtl/mvtp_datapath.sv
// Datapath: matrix store, multiply-accumulate pipeline, divider and output register.
module mvtp_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  mvtp_pkg::cmd_t      cmd,
    input  mvtp_pkg::in_word_t  in_data,
    output mvtp_pkg::status_t   status,
    output mvtp_pkg::out_word_t out_data
);

    localparam int WW = mvtp_pkg::WORD_WIDTH;
    localparam int AW = mvtp_pkg::ACC_WIDTH;

    logic signed [WW-1:0]   mat_reg [16];
    logic signed [WW-1:0]   vec_reg [4];
    logic signed [WW-1:0]   res_reg [4];
    logic signed [2*WW-1:0] prod_reg;
    logic [1:0]             prow_reg, pcol_reg;
    logic                   pvld_reg;
    logic signed [AW-1:0]   acc_reg, acc_next;
    logic [1:0]             arow_reg;
    logic                   avld_reg;
    logic                   sat_reg, dz_reg;
    logic [1:0]             dk_reg;
    mvtp_pkg::out_word_t    out_reg;
    logic signed [WW-1:0]   fin_val;
    logic                   fin_sat;
    logic                   dv_done, dv_sat;
    logic signed [WW-1:0]   dv_q;
    logic [3:0]             elem_sel;

    assign elem_sel = {cmd.mac_idx[1:0], cmd.mac_idx[3:2]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < 16; i++)
                mat_reg[i] <= (i % 5 == 0) ? mvtp_pkg::FX_ONE : '0;
        end else if (cmd.load) begin
            mat_reg[in_data.elem_index] <= in_data.elem_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pvld_reg <= 1'b0;
            avld_reg <= 1'b0;
        end else begin
            pvld_reg <= cmd.mac_go;
            avld_reg <= pvld_reg && (pcol_reg == 2'd3);
        end
    end

    always_comb
    begin
        acc_next = (pcol_reg == 2'd0) ? AW'(prod_reg) : acc_reg + AW'(prod_reg);
        fin_val  = mvtp_pkg::round_clamp(acc_reg, fin_sat);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start) begin
            vec_reg[0] <= in_data.x;
            vec_reg[1] <= in_data.y;
            vec_reg[2] <= in_data.z;
            vec_reg[3] <= (in_data.op == mvtp_pkg::OP_PROJECT) ? mvtp_pkg::FX_ONE
                                                              : in_data.w;
        end
        prod_reg <= mat_reg[elem_sel] * vec_reg[cmd.mac_idx[1:0]];
        prow_reg <= cmd.mac_idx[3:2];
        pcol_reg <= cmd.mac_idx[1:0];
        if (pvld_reg) begin
            acc_reg  <= acc_next;
            arow_reg <= prow_reg;
        end
        if (cmd.start) begin
            sat_reg <= 1'b0;
            dz_reg  <= 1'b0;
        end else if (avld_reg) begin
            res_reg[arow_reg] <= fin_val;
            sat_reg           <= sat_reg | fin_sat;
        end else if (cmd.zero_fill) begin
            for (int k = 0; k < 3; k++)
                res_reg[k] <= res_reg[k][WW-1] ? mvtp_pkg::W_MIN : mvtp_pkg::W_MAX;
            sat_reg <= 1'b1;
            dz_reg  <= 1'b1;
        end else if (dv_done) begin
            res_reg[dk_reg] <= dv_q;
            sat_reg         <= sat_reg | dv_sat;
        end
        if (cmd.div_start)
            dk_reg <= cmd.div_k;
        if (cmd.push) begin
            out_reg.rx        <= res_reg[0];
            out_reg.ry        <= res_reg[1];
            out_reg.rz        <= res_reg[2];
            out_reg.rw        <= res_reg[3];
            out_reg.div_zero  <= dz_reg;
            out_reg.saturated <= sat_reg;
        end
    end

    mvtp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .n     (res_reg[cmd.div_k]),
        .d     (res_reg[3]),
        .done  (dv_done),
        .q     (dv_q),
        .sat   (dv_sat)
    );

    assign status.mac_busy = pvld_reg | avld_reg;
    assign status.w_zero   = (res_reg[3] == '0);
    assign status.div_done = dv_done;
    assign out_data        = out_reg;

endmodule

FILE: hw/rtl/mvtp_ctrl.sv
// Controller state machine sequencing the accumulate, divide and output steps.
module mvtp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        in_op,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  mvtp_pkg::status_t status,
    output mvtp_pkg::cmd_t    cmd
);

    mvtp_pkg::state_t state_reg, state_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [1:0]       k_reg, k_next;
    logic             proj_reg, proj_next;
    logic             ov_reg, ov_next;
    logic             acc_in;
    logic             is_vec;

    assign in_ready = (state_reg == mvtp_pkg::ST_IDLE);
    assign acc_in   = in_valid && in_ready;
    assign is_vec   = (in_op == mvtp_pkg::OP_XFORM) || (in_op == mvtp_pkg::OP_PROJECT);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        proj_next  = proj_reg;
        case (state_reg)
            mvtp_pkg::ST_IDLE:
            begin
                if (acc_in && is_vec) begin
                    state_next = mvtp_pkg::ST_MAC;
                    cnt_next   = '0;
                    proj_next  = (in_op == mvtp_pkg::OP_PROJECT);
                end
            end
            mvtp_pkg::ST_MAC:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 4'd15)
                    state_next = mvtp_pkg::ST_FLUSH;
            end
            mvtp_pkg::ST_FLUSH:
            begin
                if (!status.mac_busy) begin
                    k_next = '0;
                    if (!proj_reg || status.w_zero)
                        state_next = mvtp_pkg::ST_PUSH;
                    else
                        state_next = mvtp_pkg::ST_DIV_START;
                end
            end
            mvtp_pkg::ST_DIV_START:
            begin
                state_next = mvtp_pkg::ST_DIV_WAIT;
            end
            mvtp_pkg::ST_DIV_WAIT:
            begin
                if (status.div_done) begin
                    if (k_reg == 2'd2) begin
                        state_next = mvtp_pkg::ST_PUSH;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = mvtp_pkg::ST_DIV_START;
                    end
                end
            end
            mvtp_pkg::ST_PUSH:
            begin
                if (!ov_reg || out_ready)
                    state_next = mvtp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mvtp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.load      = acc_in && (in_op == mvtp_pkg::OP_LOAD);
        cmd.start     = acc_in && is_vec;
        cmd.mac_idx   = cnt_reg;
        cmd.div_k     = k_reg;
        case (state_reg)
            mvtp_pkg::ST_MAC:       cmd.mac_go    = 1'b1;
            mvtp_pkg::ST_FLUSH:     cmd.zero_fill = !status.mac_busy && proj_reg
                                                    && status.w_zero;
            mvtp_pkg::ST_DIV_START: cmd.div_start = 1'b1;
            mvtp_pkg::ST_PUSH:      cmd.push      = !ov_reg || out_ready;
            default:                cmd.mac_go    = 1'b0;
        endcase
        ov_next = cmd.push ? 1'b1 : (out_ready ? 1'b0 : ov_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= mvtp_pkg::ST_IDLE;
            cnt_reg   <= '0;
            k_reg     <= '0;
            proj_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
            proj_reg  <= proj_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;

endmodule

FILE: hw/rtl/mat4_vertex_transform_project.sv
// Top level of the 4x4 homogeneous vertex transform with perspective divide.
//
//   channel | signals                          | word
//   in      | in_valid, in_ready, in_data      | op, element load or vector
//   out     | out_valid, out_ready, out_data   | rx, ry, rz, rw, div_zero, saturated
//
// A transform streams sixteen products through one 32x32 multiplier, drains the
// pipeline, pushes the result and returns to idle. A project adds three serial
// divisions of 48 steps each plus start and finish, unless the w result is zero.
// Reset loads the identity matrix at once. A finished result sits in the output
// register while the next word is taken; a stalled output holds the following
// result in the datapath until the register frees.
module mat4_vertex_transform_project (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mvtp_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output mvtp_pkg::out_word_t out_data
);

    mvtp_pkg::cmd_t    cmd;
    mvtp_pkg::status_t status;

    mvtp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_op     (in_data.op),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    mvtp_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .status   (status),
        .out_data (out_data)
    );

    a_dz_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.div_zero |-> out_data.saturated)
        else $error("div_zero without saturated");

    a_dz_rw: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.div_zero |-> out_data.rw == '0)
        else $error("div_zero with nonzero rw");

    a_no_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.op == mvtp_pkg::OP_XFORM |=> !$rose(out_valid))
        else $error("result appeared too early");

endmodule

FILE: sim/tb_top.sv
// Testbench for the vertex transform block: scoreboard class, stimulus and checking.
module tb_top;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    mvtp_pkg::in_word_t  in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    mvtp_pkg::out_word_t out_data;

    mat4_vertex_transform_project uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    class vertex_scoreboard;
        longint              mat [16];
        mvtp_pkg::out_word_t pending [$];
        int                  mismatches;

        function new();
            for (int i = 0; i < 16; i++)
                mat[i] = (i % 5 == 0) ? 64'sd65536 : 64'sd0;
            mismatches = 0;
        endfunction

        function longint row_sum(int r, longint vec [4], inout bit sat);
            logic signed [95:0] acc;
            acc = 0;
            for (int c = 0; c < 4; c++)
                acc += 96'(mat[c * 4 + r]) * 96'(vec[c]);
            acc = (acc + 96'sd32768) >>> 16;
            if (acc > 96'sd2147483647)
            begin
                sat = 1'b1;
                return 64'sd2147483647;
            end
            if (acc < -96'sd2147483648)
            begin
                sat = 1'b1;
                return -64'sd2147483648;
            end
            return longint'(acc);
        endfunction

        function longint fx_quot(longint n, longint d, inout bit sat);
            logic signed [95:0] q;
            q = (96'(n) <<< 16) / 96'(d);
            if (q > 96'sd2147483647)
            begin
                sat = 1'b1;
                return 64'sd2147483647;
            end
            if (q < -96'sd2147483648)
            begin
                sat = 1'b1;
                return -64'sd2147483648;
            end
            return longint'(q);
        endfunction

        function void note_input(mvtp_pkg::in_word_t w);
            longint              vec [4];
            longint              res [4];
            bit                  sat;
            mvtp_pkg::out_word_t e;
            sat = 1'b0;
            if (w.op == mvtp_pkg::OP_LOAD)
            begin
                mat[w.elem_index] = longint'(w.elem_value);
                return;
            end
            if (w.op != mvtp_pkg::OP_XFORM && w.op != mvtp_pkg::OP_PROJECT)
                return;
            vec[0] = w.x;
            vec[1] = w.y;
            vec[2] = w.z;
            vec[3] = (w.op == mvtp_pkg::OP_PROJECT) ? 64'sd65536 : longint'(w.w);
            for (int k = 0; k < 4; k++)
                res[k] = row_sum(k, vec, sat);
            e.div_zero = 1'b0;
            if (w.op == mvtp_pkg::OP_PROJECT)
            begin
                if (res[3] == 0)
                begin
                    e.div_zero = 1'b1;
                    sat = 1'b1;
                    for (int k = 0; k < 3; k++)
                        res[k] = res[k] < 0 ? -64'sd2147483648 : 64'sd2147483647;
                end
                else
                begin
                    for (int k = 0; k < 3; k++)
                        res[k] = fx_quot(res[k], res[3], sat);
                end
            end
            e.rx = res[0][31:0];
            e.ry = res[1][31:0];
            e.rz = res[2][31:0];
            e.rw = res[3][31:0];
            e.saturated = sat;
            pending.push_back(e);
        endfunction

        function void check_result(mvtp_pkg::out_word_t a);
            mvtp_pkg::out_word_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", a);
                return;
            end
            e = pending.pop_front();
            if (a !== e)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %h %h %h %h dz=%b sat=%b, %s",
                        e.rx, e.ry, e.rz, e.rw, e.div_zero, e.saturated,
                        $sformatf("got %h %h %h %h dz=%b sat=%b",
                            a.rx, a.ry, a.rz, a.rw, a.div_zero, a.saturated));
            end
        endfunction
    endclass

    vertex_scoreboard sb = new();
    bit calm = 1'b0;
    bit hold_out = 1'b0;

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_input(in_data);
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    // Receiver side: random stalls in bursts, plus one long hold-off on request.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_out)
            begin
                out_ready <= 1'b0;
                repeat (3000) @(negedge clk);
                hold_out = 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 17);
                out_ready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sd0;
            3, 4: return $signed(32'($urandom_range(0, 32'h3ffff)) - 32'h20000);
            default: return $signed($urandom());
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so the caller either sends again or drops valid.
    task automatic send_word(mvtp_pkg::in_word_t w);
        in_data <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_load(int idx, logic signed [31:0] v);
        mvtp_pkg::in_word_t w;
        w = '0;
        w.op = mvtp_pkg::OP_LOAD;
        w.elem_index = 4'(idx);
        w.elem_value = v;
        send_word(w);
    endtask

    task automatic send_vec(logic [1:0] op, logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z, logic signed [31:0] w4);
        mvtp_pkg::in_word_t w;
        w = '0;
        w.op = op;
        w.x = x;
        w.y = y;
        w.z = z;
        w.w = w4;
        w.elem_index = 4'($urandom());
        w.elem_value = $signed($urandom());
        send_word(w);
    endtask

    task automatic sender_gap();
        int n;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    initial
    begin
        mvtp_pkg::in_word_t w;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        // Directed part: identity transforms, extremes, unused op, zero divisor.
        send_vec(mvtp_pkg::OP_XFORM, 32'sh00010000, 32'sh00020000, -32'sh00030000,
                 32'sh00010000);
        send_vec(mvtp_pkg::OP_XFORM, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                 32'sh80000000);
        send_vec(mvtp_pkg::OP_PROJECT, 32'sh00050000, -32'sh00050000, 32'sd0, 32'sd0);
        w = '1;
        send_word(w);
        send_load(15, 32'sd0);
        send_vec(mvtp_pkg::OP_PROJECT, 32'sh00010000, -32'sh00010000, 32'sd0,
                 32'sh7fffffff);
        send_load(15, 32'sh00000100);
        send_vec(mvtp_pkg::OP_PROJECT, 32'sh7fffffff, 32'sh80000000, 32'sd5, 32'sd0);
        send_load(3, 32'sh80000000);
        send_load(7, 32'sh7fffffff);
        send_load(0, 32'sh7fffffff);
        send_load(5, 32'sh80000000);
        send_vec(mvtp_pkg::OP_XFORM, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
                 32'sh80000000);
        send_vec(mvtp_pkg::OP_PROJECT, 32'sh00018000, 32'sh80000000, 32'sh7fffffff,
                 32'sd0);
        send_load(15, -32'sh00010000);
        send_load(3, 32'sd0);
        send_load(7, 32'sd0);
        send_vec(mvtp_pkg::OP_PROJECT, 32'sh00030000, -32'sh00020000, 32'sh00010000,
                 32'sd0);
        wait_drained();
        // Receiver holds off while the sender keeps offering words.
        hold_out = 1'b1;
        for (int i = 0; i < 8; i++)
            send_vec(mvtp_pkg::OP_XFORM, rand_word(), rand_word(), rand_word(),
                     rand_word());
        // Random part.
        for (int i = 0; i < 1400; i++)
        begin
            if (i > 1250)
                calm = 1'b1;
            if (i == 600)
                wait_drained();
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4: send_load($urandom_range(0, 15), rand_word());
                5:
                begin
                    w = '0;
                    w.op = mvtp_pkg::OP_NOP;
                    w.elem_index = 4'($urandom());
                    w.elem_value = $signed($urandom());
                    w.x = rand_word();
                    w.y = rand_word();
                    w.z = rand_word();
                    w.w = rand_word();
                    send_word(w);
                end
                6, 7, 8, 9, 10, 11: send_vec(mvtp_pkg::OP_XFORM, rand_word(), rand_word(),
                                             rand_word(), rand_word());
                default: send_vec(mvtp_pkg::OP_PROJECT, rand_word(), rand_word(),
                                  rand_word(), rand_word());
            endcase
            sender_gap();
        end
        wait_drained();
        if (sb.mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("tb_top failed");
        $finish;
    end
endmodule
